### rtl/core/gnuf_pkg.sv
`default_nettype none
package gnuf_pkg;

  localparam int unsigned MAX_LEN      = 512;
  localparam int unsigned LEN_MIN      = 16;
  localparam int unsigned LEN_MAX      = 1024;
  localparam int unsigned N_EVENTS     = 7;
  localparam int unsigned LEN_W        = 11;
  localparam int unsigned CODE_W       = 3;
  localparam int unsigned TOTAL_W      = 32;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned CFG_DATA_W   = 11;

  localparam logic [7:0] NMEA_DOLLAR   = 8'h24;
  localparam logic [7:0] NMEA_STAR     = 8'h2A;
  localparam logic [7:0] UBX_SYNC1     = 8'hB5;
  localparam logic [7:0] UBX_SYNC2     = 8'h62;
  localparam logic [7:0] END_CHAR_RST  = 8'h0A;
  localparam logic [16:0] UBX_OVERHEAD = 17'd8;
  localparam logic [LEN_W-1:0] UBX_HEADER = 11'd6;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_FRAME_LENGTH = 1'b0,
    REG_NMEA_END_CHAR    = 1'b1
  } reg_idx_t;

  typedef enum logic [CODE_W-1:0] {
    EV_BAD_START     = 3'd0,
    EV_NMEA_OK       = 3'd1,
    EV_NMEA_BAD_SUM  = 3'd2,
    EV_UBX_OK        = 3'd3,
    EV_UBX_BAD_SUM   = 3'd4,
    EV_UBX_MALFORMED = 3'd5,
    EV_OVERFLOW      = 3'd6
  } event_code_t;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'b001,
    MODE_NMEA = 3'b010,
    MODE_UBX  = 3'b100
  } rx_mode_t;

  typedef enum logic [3:0] {
    PH_BODY   = 4'b0001,
    PH_DIGIT1 = 4'b0010,
    PH_DIGIT2 = 4'b0100,
    PH_DONE   = 4'b1000
  } nmea_phase_t;

endpackage
`default_nettype wire

### rtl/core/gnuf_rx_if.sv
`default_nettype none
interface gnuf_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

### rtl/core/gnuf_evt_if.sv
`default_nettype none
interface gnuf_evt_if;
  logic                          valid;
  logic                          ready;
  logic [gnuf_pkg::CODE_W-1:0]   event_code;
  logic [gnuf_pkg::LEN_W-1:0]    frame_length;
  logic [gnuf_pkg::TOTAL_W-1:0]  event_total;

  modport source (output valid, output event_code, output frame_length,
                  output event_total, input ready);
  modport sink   (input valid, input event_code, input frame_length,
                  input event_total, output ready);
endinterface
`default_nettype wire

### rtl/core/gnuf_ram.sv
`default_nettype none
module gnuf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### rtl/core/gps_nmea_ubx_framer.sv
// GPS NMEA / UBX message framer.
// rx: one received serial byte per request (valid/ready). evt: one event
// request per framing event, carrying the event code, the frame length
// (zero unless a checksum was judged) and its 32-bit wrapping counter.
// cfg_we/cfg_index/cfg_data write max_frame_length (index 0, clamped to
// 16..1024) and nmea_end_char (index 1); write only while idle.
// Throughput: one byte per cycle while rx ready is high. Framing state
// updates as the byte is taken; an event reads its counter from the
// counter RAM into the counter stage, which adds one and, as it
// advances, writes the sum back and loads the output register.
// Back-to-back events on the same counter are forwarded around the RAM.
// The receiver may stall: the output register holds, one more event
// waits in the counter stage, and rx ready drops only once both are full.
// Reset (synchronous) returns the framer to idle, restores the register
// defaults and clears all counters at once through per-entry valid bits.
`default_nettype none
module gps_nmea_ubx_framer (
  input  wire logic                              clk,
  input  wire logic                              rst,
  gnuf_rx_if.sink                                rx,
  gnuf_evt_if.source                             evt,
  input  wire logic                              cfg_we,
  input  wire logic [gnuf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [gnuf_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int unsigned LW = gnuf_pkg::LEN_W;
  localparam int unsigned CW = gnuf_pkg::CODE_W;
  localparam int unsigned TW = gnuf_pkg::TOTAL_W;

  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b0, 4'(c - 8'h30)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b0, 4'(c - 8'h41 + 8'd10)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b0, 4'(c - 8'h61 + 8'd10)};
    return r;
  endfunction

  logic [LW-1:0] max_frame_length;
  logic [7:0]    nmea_end_char;

  gnuf_pkg::rx_mode_t    rx_mode, rx_mode_next;
  gnuf_pkg::nmea_phase_t nmea_phase, nmea_phase_next;
  logic [LW-1:0] byte_count, byte_count_next;
  logic [15:0]   ubx_payload_len, ubx_payload_len_next;
  logic [7:0]    nmea_xor_sum, nmea_xor_sum_next;
  logic [7:0]    nmea_given_sum, nmea_given_sum_next;
  logic          nmea_digit_bad, nmea_digit_bad_next;
  logic [7:0]    fletcher_a, fletcher_a_next;
  logic [7:0]    fletcher_b, fletcher_b_next;
  logic [7:0]    ubx_first_check, ubx_first_check_next;

  logic          ev_fire;
  gnuf_pkg::event_code_t ev_code;
  logic [LW-1:0] ev_len;

  logic [7:0]    b;
  logic [LW-1:0] bc;
  logic [16:0]   bc_ext;
  logic [16:0]   ubx_end;
  logic [4:0]    hv;
  logic          done;
  logic [7:0]    fa_sum;

  logic          acc;
  logic          s1_valid;
  logic [CW-1:0] s1_code;
  logic [LW-1:0] s1_len;
  logic          s1_go;
  logic [TW-1:0] rdata;
  logic [TW-1:0] cnt_base;
  logic [TW-1:0] cnt_total;
  logic [gnuf_pkg::N_EVENTS-1:0] cnt_valid;
  logic          fwd_valid;
  logic [CW-1:0] fwd_addr;
  logic [TW-1:0] fwd_data;
  logic          out_valid;
  logic [CW-1:0] out_code;
  logic [LW-1:0] out_len;
  logic [TW-1:0] out_total;
  logic [LW-1:0] cfg_len;

  assign acc      = rx.valid && rx.ready;
  assign s1_go    = s1_valid && (!out_valid || evt.ready);
  assign rx.ready = !s1_valid || s1_go;

  assign b       = rx.rx_byte;
  assign bc      = byte_count + LW'(1);
  assign bc_ext  = {6'b0, bc};
  assign ubx_end = {1'b0, ubx_payload_len} + gnuf_pkg::UBX_OVERHEAD;
  assign hv      = hex_value(b);

  always_comb begin
    rx_mode_next         = rx_mode;
    nmea_phase_next      = nmea_phase;
    byte_count_next      = bc;
    ubx_payload_len_next = ubx_payload_len;
    nmea_xor_sum_next    = nmea_xor_sum;
    nmea_given_sum_next  = nmea_given_sum;
    nmea_digit_bad_next  = nmea_digit_bad;
    fletcher_a_next      = fletcher_a;
    fletcher_b_next      = fletcher_b;
    ubx_first_check_next = ubx_first_check;
    ev_fire              = 1'b0;
    ev_code              = gnuf_pkg::EV_BAD_START;
    ev_len               = '0;
    done                 = 1'b0;
    fa_sum               = fletcher_a + b;

    unique case (rx_mode)
      gnuf_pkg::MODE_NMEA: begin
        if (b == nmea_end_char) begin
          done            = 1'b1;
          ev_fire         = 1'b1;
          ev_code         = (nmea_phase == gnuf_pkg::PH_DONE && !nmea_digit_bad &&
                             nmea_given_sum == nmea_xor_sum) ?
                            gnuf_pkg::EV_NMEA_OK : gnuf_pkg::EV_NMEA_BAD_SUM;
          ev_len          = bc;
          rx_mode_next    = gnuf_pkg::MODE_IDLE;
          byte_count_next = '0;
        end else begin
          unique case (nmea_phase)
            gnuf_pkg::PH_BODY: begin
              if (b == gnuf_pkg::NMEA_STAR) nmea_phase_next = gnuf_pkg::PH_DIGIT1;
              else nmea_xor_sum_next = nmea_xor_sum ^ b;
            end
            gnuf_pkg::PH_DIGIT1: begin
              if (hv[4]) begin
                nmea_digit_bad_next = 1'b1;
                nmea_phase_next     = gnuf_pkg::PH_DONE;
              end else begin
                nmea_given_sum_next = {hv[3:0], 4'h0};
                nmea_phase_next     = gnuf_pkg::PH_DIGIT2;
              end
            end
            gnuf_pkg::PH_DIGIT2: begin
              if (hv[4]) begin
                nmea_digit_bad_next = 1'b1;
              end else begin
                nmea_given_sum_next = {nmea_given_sum[7:4], hv[3:0]};
              end
              nmea_phase_next = gnuf_pkg::PH_DONE;
            end
            default: begin
            end
          endcase
        end
      end
      gnuf_pkg::MODE_UBX: begin
        if (bc == LW'(2)) begin
          if (b != gnuf_pkg::UBX_SYNC2) begin
            done            = 1'b1;
            ev_fire         = 1'b1;
            ev_code         = gnuf_pkg::EV_UBX_MALFORMED;
            rx_mode_next    = gnuf_pkg::MODE_IDLE;
            byte_count_next = '0;
          end
        end else if (bc <= gnuf_pkg::UBX_HEADER) begin
          if (bc == LW'(5)) ubx_payload_len_next = {8'h00, b};
          if (bc == gnuf_pkg::UBX_HEADER) ubx_payload_len_next = {b, ubx_payload_len[7:0]};
          fletcher_a_next = fa_sum;
          fletcher_b_next = fletcher_b + fa_sum;
        end else if (bc_ext >= ubx_end) begin
          done            = 1'b1;
          ev_fire         = 1'b1;
          ev_code         = (ubx_first_check == fletcher_a && b == fletcher_b) ?
                            gnuf_pkg::EV_UBX_OK : gnuf_pkg::EV_UBX_BAD_SUM;
          ev_len          = bc;
          rx_mode_next    = gnuf_pkg::MODE_IDLE;
          byte_count_next = '0;
        end else if (bc_ext == ubx_end - 17'd1) begin
          ubx_first_check_next = b;
        end else begin
          fletcher_a_next = fa_sum;
          fletcher_b_next = fletcher_b + fa_sum;
        end
      end
      default: begin
        rx_mode_next = gnuf_pkg::MODE_IDLE;
        if (b == gnuf_pkg::NMEA_DOLLAR) begin
          rx_mode_next        = gnuf_pkg::MODE_NMEA;
          nmea_phase_next     = gnuf_pkg::PH_BODY;
          nmea_xor_sum_next   = '0;
          nmea_given_sum_next = '0;
          nmea_digit_bad_next = 1'b0;
        end else if (b == gnuf_pkg::UBX_SYNC1) begin
          rx_mode_next         = gnuf_pkg::MODE_UBX;
          fletcher_a_next      = '0;
          fletcher_b_next      = '0;
          ubx_first_check_next = '0;
        end else begin
          done            = 1'b1;
          ev_fire         = 1'b1;
          ev_code         = gnuf_pkg::EV_BAD_START;
          byte_count_next = '0;
        end
      end
    endcase

    if (!done && bc >= max_frame_length) begin
      ev_fire         = 1'b1;
      ev_code         = gnuf_pkg::EV_OVERFLOW;
      ev_len          = '0;
      rx_mode_next    = gnuf_pkg::MODE_IDLE;
      byte_count_next = '0;
    end
  end

  always_comb begin
    cfg_len = cfg_data;
    if (cfg_data < LW'(gnuf_pkg::LEN_MIN)) cfg_len = LW'(gnuf_pkg::LEN_MIN);
    else if (cfg_data > LW'(gnuf_pkg::LEN_MAX)) cfg_len = LW'(gnuf_pkg::LEN_MAX);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_length <= LW'(gnuf_pkg::MAX_LEN);
      nmea_end_char    <= gnuf_pkg::END_CHAR_RST;
    end else if (cfg_we) begin
      unique case (gnuf_pkg::reg_idx_t'(cfg_index))
        gnuf_pkg::REG_MAX_FRAME_LENGTH: max_frame_length <= cfg_len;
        gnuf_pkg::REG_NMEA_END_CHAR:    nmea_end_char    <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_mode         <= gnuf_pkg::MODE_IDLE;
      nmea_phase      <= gnuf_pkg::PH_BODY;
      byte_count      <= '0;
      ubx_payload_len <= '0;
      nmea_xor_sum    <= '0;
      nmea_given_sum  <= '0;
      nmea_digit_bad  <= 1'b0;
      fletcher_a      <= '0;
      fletcher_b      <= '0;
      ubx_first_check <= '0;
    end else if (acc) begin
      rx_mode         <= rx_mode_next;
      nmea_phase      <= nmea_phase_next;
      byte_count      <= byte_count_next;
      ubx_payload_len <= ubx_payload_len_next;
      nmea_xor_sum    <= nmea_xor_sum_next;
      nmea_given_sum  <= nmea_given_sum_next;
      nmea_digit_bad  <= nmea_digit_bad_next;
      fletcher_a      <= fletcher_a_next;
      fletcher_b      <= fletcher_b_next;
      ubx_first_check <= ubx_first_check_next;
    end
  end

  gnuf_ram #(
    .WIDTH (TW),
    .DEPTH (gnuf_pkg::N_EVENTS)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (s1_go),
    .waddr (s1_code),
    .wdata (cnt_total),
    .re    (acc && ev_fire),
    .raddr (ev_code),
    .rdata (rdata)
  );

  // write landing on the read edge is not seen by the RAM read
  always_comb begin
    if (fwd_valid && fwd_addr == s1_code) cnt_base = fwd_data;
    else if (cnt_valid[s1_code]) cnt_base = rdata;
    else cnt_base = '0;
  end
  assign cnt_total = cnt_base + TW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      fwd_valid <= 1'b0;
      cnt_valid <= '0;
    end else begin
      if (acc && ev_fire) begin
        s1_valid  <= 1'b1;
        fwd_valid <= s1_go;
      end else if (s1_go) begin
        s1_valid  <= 1'b0;
      end
      if (s1_go) begin
        out_valid          <= 1'b1;
        cnt_valid[s1_code] <= 1'b1;
      end else if (evt.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && ev_fire) begin
      s1_code  <= ev_code;
      s1_len   <= ev_len;
      fwd_addr <= s1_code;
      fwd_data <= cnt_total;
    end
    if (s1_go) begin
      out_code  <= s1_code;
      out_len   <= s1_len;
      out_total <= cnt_total;
    end
  end

  assign evt.valid        = out_valid;
  assign evt.event_code   = out_code;
  assign evt.frame_length = out_len;
  assign evt.event_total  = out_total;

endmodule
`default_nettype wire
